### rtl/core/esc_pkg.sv
// esc_pkg: shared types, constants and helper functions of the elevator scan controller
// no dependencies

package esc_pkg;

    localparam int FLOORS  = 5;
    localparam int FLOOR_W = 3;
    localparam int TICK_W  = 16;
    localparam int RIDER_W = 4;
    localparam int SEG_W   = 7;
    localparam int CFG_A_W = 2;

    localparam logic [FLOORS-1:0]  FLOOR_MASK = {FLOORS{1'b1}};
    localparam logic [TICK_W-1:0]  TICK_MAX   = {TICK_W{1'b1}};
    localparam logic [RIDER_W-1:0] RIDER_MAX  = {RIDER_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_DOOR_TICKS   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_TRAVEL_TICKS = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_CAPACITY     = 2'd2;

    localparam logic [TICK_W-1:0]  DOOR_TICKS_RST   = 16'd1000;
    localparam logic [TICK_W-1:0]  TRAVEL_TICKS_RST = 16'd1000;
    localparam logic [RIDER_W-1:0] CAPACITY_RST     = 4'd4;

    // seven-segment digits, bit0 is segment a
    localparam logic [SEG_W-1:0] SEG_0 = 7'h3F;
    localparam logic [SEG_W-1:0] SEG_1 = 7'h06;
    localparam logic [SEG_W-1:0] SEG_2 = 7'h5B;
    localparam logic [SEG_W-1:0] SEG_3 = 7'h4F;
    localparam logic [SEG_W-1:0] SEG_4 = 7'h66;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MOVE = 3'b010,
        PH_DOOR = 3'b100
    } t_phase;

    function automatic logic [SEG_W-1:0] seg_of(input logic [FLOOR_W-1:0] f);
        logic [SEG_W-1:0] s;
        case (f)
            3'd0:    s = SEG_0;
            3'd1:    s = SEG_1;
            3'd2:    s = SEG_2;
            3'd3:    s = SEG_3;
            3'd4:    s = SEG_4;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [FLOORS-1:0] own_mask(input logic [FLOOR_W-1:0] f);
        logic [FLOORS-1:0] m;
        for (int i = 0; i < FLOORS; i++) begin
            m[i] = (i == int'(f));
        end
        return m;
    endfunction

    // pending floors that lie in the direction of travel
    function automatic logic [FLOORS-1:0] ahead_mask(input logic [FLOORS-1:0]  pend,
                                                     input logic [FLOOR_W-1:0] f,
                                                     input logic               up);
        logic [FLOORS-1:0] m;
        for (int i = 0; i < FLOORS; i++) begin
            m[i] = pend[i] && (up ? (i > int'(f)) : (i < int'(f)));
        end
        return m;
    endfunction

endpackage

### rtl/core/elevator_scan_controller.sv
// elevator_scan_controller: SCAN scheduled car, door timing, passenger counting
// depends on esc_pkg
//
// the result item is registered at the edge that accepts its input item
// throughput: one item per cycle; input is taken while a result waits if it is taken too
// reset: synchronous active-low, car at floor 0 heading up, idle, no requests,
// configuration back to its defaults, no result pending

module elevator_scan_controller
    import esc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [TICK_W-1:0]  i_cfg_wdata,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FLOORS-1:0]  i_cab_buttons,
    input  logic [FLOORS-1:0]  i_hall_up,
    input  logic [FLOORS-1:0]  i_hall_down,
    input  logic               i_door_button,
    input  logic               i_beam_outer,
    input  logic               i_beam_inner,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [FLOOR_W-1:0] o_car_floor,
    output logic [SEG_W-1:0]   o_segments,
    output logic               o_motor_up,
    output logic               o_motor_down,
    output logic               o_door_open,
    output logic               o_ready_lamp,
    output logic               o_overload_flag,
    output logic [RIDER_W-1:0] o_passenger_count
);

    // configuration
    logic [TICK_W-1:0]  r_door_ticks;
    logic [TICK_W-1:0]  r_travel_ticks;
    logic [RIDER_W-1:0] r_capacity;

    // controller state
    logic [FLOOR_W-1:0] r_floor,      n_floor;
    logic [FLOORS-1:0]  r_pending,    n_pending;
    logic               r_heading_up, n_heading_up;
    t_phase             r_phase,      n_phase;
    logic [TICK_W-1:0]  r_timer,      n_timer;
    logic [RIDER_W-1:0] r_riders,     n_riders;
    logic               r_entering,   n_entering;
    logic               r_leaving,    n_leaving;
    logic               r_overloaded, n_overloaded;

    // result register
    logic               r_out_valid;
    logic [FLOOR_W-1:0] r_car_floor;
    logic [SEG_W-1:0]   r_segments;
    logic               r_motor_up;
    logic               r_motor_down;
    logic               r_door_open;
    logic               r_ready_lamp;
    logic               r_overload_flag;
    logic [RIDER_W-1:0] r_passenger_count;

    logic               in_acc;
    logic [TICK_W-1:0]  timer_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign timer_inc  = (r_timer == TICK_MAX) ? TICK_MAX : r_timer + 1'b1;

    always_comb begin
        logic [FLOORS-1:0] own;

        n_floor      = r_floor;
        n_pending    = (r_pending | i_cab_buttons | i_hall_up | i_hall_down) & FLOOR_MASK;
        n_heading_up = r_heading_up;
        n_phase      = r_phase;
        n_timer      = r_timer;
        n_riders     = r_riders;
        n_entering   = r_entering;
        n_leaving    = r_leaving;
        n_overloaded = r_overloaded;
        own          = own_mask(r_floor);

        case (r_phase)
            PH_MOVE: begin
                if (timer_inc >= r_travel_ticks) begin
                    if (r_heading_up) begin
                        n_floor = r_floor + 1'b1;
                    end else if (r_floor != '0) begin
                        n_floor = r_floor - 1'b1;
                    end
                    n_timer = '0;
                    own     = own_mask(n_floor);
                    if ((n_pending & own) != '0) begin
                        n_pending = n_pending & ~own;
                        n_phase   = PH_DOOR;
                    end else if (ahead_mask(n_pending, n_floor, r_heading_up) == '0) begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_DOOR: begin
                // outer then inner is one rider in, inner then outer is one out
                if (!i_beam_outer && i_beam_inner) begin
                    if (r_leaving) begin
                        if (r_riders != '0) begin
                            n_riders = r_riders - 1'b1;
                        end
                        n_leaving = 1'b0;
                    end else begin
                        n_entering = 1'b1;
                    end
                end else if (i_beam_outer && !i_beam_inner) begin
                    if (r_entering) begin
                        if (r_riders != RIDER_MAX) begin
                            n_riders = r_riders + 1'b1;
                        end
                        n_entering = 1'b0;
                    end else begin
                        n_leaving = 1'b1;
                    end
                end
                if (i_door_button || (n_pending & own) != '0) begin
                    n_pending = n_pending & ~own;
                    n_timer   = '0;
                end else if (timer_inc >= r_door_ticks) begin
                    n_timer = '0;
                    if (n_riders > r_capacity) begin
                        n_overloaded = 1'b1;
                    end else begin
                        n_overloaded = 1'b0;
                        n_phase      = PH_IDLE;
                    end
                end else begin
                    n_timer = timer_inc;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if ((n_pending & own) != '0) begin
                    n_pending = n_pending & ~own;
                    n_phase   = PH_DOOR;
                    n_timer   = '0;
                end else if (i_door_button) begin
                    n_phase = PH_DOOR;
                    n_timer = '0;
                end else if (ahead_mask(n_pending, r_floor, r_heading_up) != '0) begin
                    n_phase = PH_MOVE;
                    n_timer = '0;
                end else if (n_pending != '0) begin
                    // nothing ahead, turn round
                    n_heading_up = !r_heading_up;
                    n_phase      = PH_MOVE;
                    n_timer      = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_ticks   <= DOOR_TICKS_RST;
            r_travel_ticks <= TRAVEL_TICKS_RST;
            r_capacity     <= CAPACITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DOOR_TICKS:   r_door_ticks   <= i_cfg_wdata;
                CFG_TRAVEL_TICKS: r_travel_ticks <= i_cfg_wdata;
                CFG_CAPACITY:     r_capacity     <= i_cfg_wdata[RIDER_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor      <= '0;
            r_pending    <= '0;
            r_heading_up <= 1'b1;
            r_phase      <= PH_IDLE;
            r_timer      <= '0;
            r_riders     <= '0;
            r_entering   <= 1'b0;
            r_leaving    <= 1'b0;
            r_overloaded <= 1'b0;
        end else if (in_acc) begin
            r_floor      <= n_floor;
            r_pending    <= n_pending;
            r_heading_up <= n_heading_up;
            r_phase      <= n_phase;
            r_timer      <= n_timer;
            r_riders     <= n_riders;
            r_entering   <= n_entering;
            r_leaving    <= n_leaving;
            r_overloaded <= n_overloaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result fields reflect the state after the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_car_floor       <= n_floor;
            r_segments        <= seg_of(n_floor);
            r_motor_up        <= (n_phase == PH_MOVE) && n_heading_up;
            r_motor_down      <= (n_phase == PH_MOVE) && !n_heading_up;
            r_door_open       <= (n_phase == PH_DOOR);
            r_ready_lamp      <= (n_phase != PH_DOOR) && !n_overloaded;
            r_overload_flag   <= n_overloaded;
            r_passenger_count <= n_riders;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_car_floor       = r_car_floor;
    assign o_segments        = r_segments;
    assign o_motor_up        = r_motor_up;
    assign o_motor_down      = r_motor_down;
    assign o_door_open       = r_door_open;
    assign o_ready_lamp      = r_ready_lamp;
    assign o_overload_flag   = r_overload_flag;
    assign o_passenger_count = r_passenger_count;

endmodule

### dv/elevator_scan_controller_tb.sv
`timescale 1ns / 100ps
// elevator_scan_controller_tb: self-checking bench for the elevator scan controller
// a cycle model of the car predicts every status item; depends on esc_pkg and the rtl

module elevator_scan_controller_tb;
    import esc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [FLOORS-1:0] cab;
        logic [FLOORS-1:0] hall_up;
        logic [FLOORS-1:0] hall_down;
        logic              door_btn;
        logic              beam_outer;
        logic              beam_inner;
    } t_tick;

    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        logic [SEG_W-1:0]   segments;
        logic               motor_up;
        logic               motor_down;
        logic               door_open;
        logic               ready_lamp;
        logic               overload;
        logic [RIDER_W-1:0] riders;
    } t_status;

    typedef enum logic [1:0] {
        BEAMS_RANDOM,
        BEAMS_BOARDING,
        BEAMS_ALIGHTING
    } t_beam_mix;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [CFG_A_W-1:0] i_cfg_addr   = CFG_DOOR_TICKS;
    logic [TICK_W-1:0]  i_cfg_wdata  = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic [FLOORS-1:0]  i_cab_buttons = '0;
    logic [FLOORS-1:0]  i_hall_up     = '0;
    logic [FLOORS-1:0]  i_hall_down   = '0;
    logic               i_door_button = 1'b0;
    logic               i_beam_outer  = 1'b1;
    logic               i_beam_inner  = 1'b1;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [FLOOR_W-1:0] o_car_floor;
    logic [SEG_W-1:0]   o_segments;
    logic               o_motor_up;
    logic               o_motor_down;
    logic               o_door_open;
    logic               o_ready_lamp;
    logic               o_overload_flag;
    logic [RIDER_W-1:0] o_passenger_count;

    // car model state and its copy of the registers
    logic [FLOOR_W-1:0] sim_floor;
    logic [FLOORS-1:0]  sim_pending;
    logic               sim_heading_up;
    t_phase             sim_phase;
    logic [TICK_W-1:0]  sim_timer;
    logic [RIDER_W-1:0] sim_riders;
    logic               sim_entering;
    logic               sim_leaving;
    logic               sim_overload;
    logic [TICK_W-1:0]  cfg_door_ticks;
    logic [TICK_W-1:0]  cfg_travel_ticks;
    logic [RIDER_W-1:0] cfg_capacity;

    t_status expected_status[$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    logic    hold_request   = 1'b0;
    int      beam_seq_pos   = 0;

    elevator_scan_controller u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cab_buttons     (i_cab_buttons),
        .i_hall_up         (i_hall_up),
        .i_hall_down       (i_hall_down),
        .i_door_button     (i_door_button),
        .i_beam_outer      (i_beam_outer),
        .i_beam_inner      (i_beam_inner),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_car_floor       (o_car_floor),
        .o_segments        (o_segments),
        .o_motor_up        (o_motor_up),
        .o_motor_down      (o_motor_down),
        .o_door_open       (o_door_open),
        .o_ready_lamp      (o_ready_lamp),
        .o_overload_flag   (o_overload_flag),
        .o_passenger_count (o_passenger_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_car();
        sim_floor        = '0;
        sim_pending      = '0;
        sim_heading_up   = 1'b1;
        sim_phase        = PH_IDLE;
        sim_timer        = '0;
        sim_riders       = '0;
        sim_entering     = 1'b0;
        sim_leaving      = 1'b0;
        sim_overload     = 1'b0;
        cfg_door_ticks   = DOOR_TICKS_RST;
        cfg_travel_ticks = TRAVEL_TICKS_RST;
        cfg_capacity     = CAPACITY_RST;
    endfunction

    // a limit of zero behaves as one since the count is at least one here
    function automatic logic timer_expired(input logic [TICK_W-1:0] limit);
        logic [TICK_W:0] count;
        count = {1'b0, sim_timer} + 1'b1;
        if (count > {1'b0, TICK_MAX}) count = {1'b0, TICK_MAX};
        sim_timer = count[TICK_W-1:0];
        return count >= {1'b0, limit};
    endfunction

    function automatic logic [FLOORS-1:0] requests_ahead();
        logic [31:0] above;
        logic [31:0] below;
        above = ~((32'd2 << sim_floor) - 32'd1);
        below = (32'd1 << sim_floor) - 32'd1;
        return sim_pending & FLOORS'(sim_heading_up ? above : below);
    endfunction

    function automatic t_status advance_car(input t_tick t);
        logic [FLOORS-1:0] own;
        t_status           s;
        sim_pending = sim_pending | t.cab | t.hall_up | t.hall_down;
        own = FLOORS'(32'd1 << sim_floor);
        case (sim_phase)
            PH_MOVE: begin
                if (timer_expired(cfg_travel_ticks)) begin
                    if (sim_heading_up) sim_floor = sim_floor + 1'b1;
                    else if (sim_floor != '0) sim_floor = sim_floor - 1'b1;
                    sim_timer = '0;
                    own = FLOORS'(32'd1 << sim_floor);
                    if ((sim_pending & own) != '0) begin
                        sim_pending &= ~own;
                        sim_phase = PH_DOOR;
                    end else if (requests_ahead() == '0) begin
                        sim_phase = PH_IDLE;
                    end
                end
            end
            PH_DOOR: begin
                if (!t.beam_outer && t.beam_inner) begin
                    if (sim_leaving) begin
                        if (sim_riders != '0) sim_riders = sim_riders - 1'b1;
                        sim_leaving = 1'b0;
                    end else begin
                        sim_entering = 1'b1;
                    end
                end else if (t.beam_outer && !t.beam_inner) begin
                    if (sim_entering) begin
                        if (sim_riders != RIDER_MAX) sim_riders = sim_riders + 1'b1;
                        sim_entering = 1'b0;
                    end else begin
                        sim_leaving = 1'b1;
                    end
                end
                if (t.door_btn || (sim_pending & own) != '0) begin
                    sim_pending &= ~own;
                    sim_timer = '0;
                end else if (timer_expired(cfg_door_ticks)) begin
                    sim_timer = '0;
                    if (sim_riders > cfg_capacity) begin
                        sim_overload = 1'b1;
                    end else begin
                        sim_overload = 1'b0;
                        sim_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                sim_phase = PH_IDLE;
                if ((sim_pending & own) != '0) begin
                    sim_pending &= ~own;
                    sim_phase = PH_DOOR;
                    sim_timer = '0;
                end else if (t.door_btn) begin
                    sim_phase = PH_DOOR;
                    sim_timer = '0;
                end else if (requests_ahead() != '0) begin
                    sim_phase = PH_MOVE;
                    sim_timer = '0;
                end else if (sim_pending != '0) begin
                    // nothing ahead, turn round
                    sim_heading_up = !sim_heading_up;
                    sim_phase = PH_MOVE;
                    sim_timer = '0;
                end
            end
        endcase

        s.car_floor = sim_floor;
        case (sim_floor)
            3'd0:    s.segments = SEG_0;
            3'd1:    s.segments = SEG_1;
            3'd2:    s.segments = SEG_2;
            3'd3:    s.segments = SEG_3;
            3'd4:    s.segments = SEG_4;
            default: s.segments = '0;
        endcase
        s.motor_up   = (sim_phase == PH_MOVE) && sim_heading_up;
        s.motor_down = (sim_phase == PH_MOVE) && !sim_heading_up;
        s.door_open  = (sim_phase == PH_DOOR);
        s.ready_lamp = (sim_phase != PH_DOOR) && !sim_overload;
        s.overload   = sim_overload;
        s.riders     = sim_riders;
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // predicts on every accepted item, checks every accepted status item
    always @(posedge i_clk) begin : monitor
        t_tick   seen;
        t_status want;
        logic    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DOOR_TICKS:   cfg_door_ticks = i_cfg_wdata;
                    CFG_TRAVEL_TICKS: cfg_travel_ticks = i_cfg_wdata;
                    CFG_CAPACITY:     cfg_capacity = i_cfg_wdata[RIDER_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_status.size() == 0) begin
                    $error("status item arrived with none expected");
                    mismatch_count++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("car_floor", 16'(want.car_floor), 16'(o_car_floor));
                    check_field("segments", 16'(want.segments), 16'(o_segments));
                    check_field("motor_up", 16'(want.motor_up), 16'(o_motor_up));
                    check_field("motor_down", 16'(want.motor_down), 16'(o_motor_down));
                    check_field("door_open", 16'(want.door_open), 16'(o_door_open));
                    check_field("ready_lamp", 16'(want.ready_lamp), 16'(o_ready_lamp));
                    check_field("overload_flag", 16'(want.overload), 16'(o_overload_flag));
                    check_field("passenger_count", 16'(want.riders),
                                16'(o_passenger_count));
                end
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                seen = {i_cab_buttons, i_hall_up, i_hall_down,
                        i_door_button, i_beam_outer, i_beam_inner};
                expected_status.push_back(advance_car(seen));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // status receiver: random stalls, or one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_tick(input t_tick t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cab_buttons <= t.cab;
        i_hall_up     <= t.hall_up;
        i_hall_down   <= t.hall_down;
        i_door_button <= t.door_btn;
        i_beam_outer  <= t.beam_outer;
        i_beam_inner  <= t.beam_inner;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_fields(input logic [FLOORS-1:0] cab, input logic [FLOORS-1:0] up,
                               input logic [FLOORS-1:0] down, input logic btn,
                               input logic outer, input logic inner);
        send_tick({cab, up, down, btn, outer, inner});
    endtask

    // the queue is looked at off the rising edge so the monitor has already run
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_status.size() != 0) @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [TICK_W-1:0] door, input logic [TICK_W-1:0] travel,
                                input logic [RIDER_W-1:0] cap);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_DOOR_TICKS;
        i_cfg_wdata <= door;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_TRAVEL_TICKS;
        i_cfg_wdata <= travel;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_CAPACITY;
        i_cfg_wdata <= TICK_W'(cap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [FLOORS-1:0] random_buttons(input int press_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return FLOORS'($urandom);
        if (roll < 3 + press_pct) return FLOORS'(32'd1 << $urandom_range(FLOORS - 1));
        return '0;
    endfunction

    function automatic t_tick random_tick(input int press_pct, input int door_pct,
                                          input t_beam_mix mix);
        t_tick t;
        t.cab       = random_buttons(press_pct);
        t.hall_up   = random_buttons(press_pct);
        t.hall_down = random_buttons(press_pct);
        t.door_btn  = ($urandom_range(99) < door_pct);
        {t.beam_outer, t.beam_inner} = 2'b11;
        if (mix == BEAMS_RANDOM) begin
            if ($urandom_range(99) < 30) {t.beam_outer, t.beam_inner} = 2'($urandom);
        end else if ($urandom_range(99) >= 20) begin
            // outer cut twice then inner cut boards one rider, mirrored for alighting
            if ((beam_seq_pos == 2) == (mix == BEAMS_BOARDING))
                {t.beam_outer, t.beam_inner} = 2'b10;
            else
                {t.beam_outer, t.beam_inner} = 2'b01;
            beam_seq_pos = (beam_seq_pos == 2) ? 0 : beam_seq_pos + 1;
        end
        return t;
    endfunction

    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b1);
        send_fields(5'b00100, '0, '0, 1'b0, 1'b1, 1'b1);
        // door button has no effect while moving
        repeat (4) send_fields('0, '0, '0, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_own_floor_and_counting();
        write_config(16'd3, 16'd1, 4'd0);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b1);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b1);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b0);
        send_fields('0, '0, '0, 1'b0, 1'b0, 1'b1);
        send_fields('0, '0, '0, 1'b1, 1'b0, 1'b1);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b0);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b1);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b1);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b0);
        send_fields('0, '0, '0, 1'b0, 1'b0, 1'b1);
        send_fields('0, '0, '0, 1'b0, 1'b1, 1'b1);
        // call at the car's own floor reopens the door
        send_fields('0, 5'b00100, '0, 1'b0, 1'b1, 1'b1);
        send_fields(5'b11111, 5'b11111, 5'b11111, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_scan_sweep();
        repeat (6) send_fields('0, '0, '0, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input int n, input logic [TICK_W-1:0] door,
                                       input logic [TICK_W-1:0] travel,
                                       input logic [RIDER_W-1:0] cap,
                                       input int idle_pct, input int stall_pct);
        write_config(door, travel, cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_tick(random_tick(8, 5, BEAMS_RANDOM));
    endtask

    task automatic test_crowd_saturation();
        write_config(16'd20, 16'd2, 4'd15);
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        repeat (150) send_tick(random_tick(0, 40, BEAMS_BOARDING));
        repeat (120) send_tick(random_tick(0, 40, BEAMS_ALIGHTING));
    endtask

    task automatic test_backpressure();
        write_config(16'd3, 16'd1, 4'd5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        repeat (80) send_tick(random_tick(10, 5, BEAMS_RANDOM));
        wait_for_results();
        repeat (40) send_tick(random_tick(10, 5, BEAMS_RANDOM));
    endtask

    task automatic test_tick_extremes();
        write_config(TICK_MAX, TICK_MAX, 4'd1);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        repeat (30) send_tick(random_tick(20, 10, BEAMS_RANDOM));
        // zero periods behave as one tick
        write_config(16'd0, 16'd0, 4'd7);
        repeat (80) send_tick(random_tick(8, 5, BEAMS_RANDOM));
    endtask

    initial begin
        reset_car();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_own_floor_and_counting();
        test_scan_sweep();
        test_random_traffic(260, 16'd4, 16'd2, 4'd2, 0, 0);
        test_random_traffic(260, 16'd1, 16'd1, 4'd0, 54, 0);
        test_random_traffic(260, 16'd8, 16'd3, 4'd15, 0, 54);
        test_random_traffic(260, TICK_W'($urandom_range(1, 10)), TICK_W'($urandom_range(1, 5)),
                            RIDER_W'($urandom_range(0, 15)), 6, 6);
        test_crowd_saturation();
        test_backpressure();
        test_tick_extremes();
        wait_for_results();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
